[hdl/dqe_pkg.sv]
// Package for the DNS QNAME label encoder: controller states, error codes,
// character constants and the result word type. Depends on nothing.
package dqe_pkg;

	// Width of the label character counter; it holds any label length up to 62.
	localparam int CNT_W = 6;

	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] END_BYTE = 8'h00;

	localparam logic [1:0] ERR_OK          = 2'd0;
	localparam logic [1:0] ERR_LEADING_DOT = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG    = 2'd2;
	localparam logic [1:0] ERR_EMPTY_LABEL = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_DATA,
		ST_END,
		ST_ERR
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       name_done;
		logic [1:0] err_code;
	} out_word_t;

endpackage

[hdl/dqe_ifs.sv]
// Valid/ready channel interfaces of the DNS QNAME label encoder: the character
// input channel and the QNAME byte output channel. Depends on nothing.
interface dqe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       is_end;

	modport source (output valid, output ch, output is_end, input ready);
	modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface dqe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       name_done;
	logic [1:0] err_code;

	modport source (output valid, output out_byte, output last_of_run,
		output name_done, output err_code, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input name_done, input err_code, output ready);
endinterface

[hdl/dqe_label_ram.sv]
// Label character store of the DNS QNAME label encoder: a simple dual-port
// synchronous RAM with a registered read port. Depends on nothing.
module dqe_label_ram #(
	parameter int DEPTH = 62,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/dns_qname_label_encoder.sv]
// Top level of the DNS QNAME label encoder: controller, counters and output
// register around the label RAM. Depends on dqe_pkg, dqe_ifs and dqe_label_ram.
//
//   Channel  Direction  Word fields                                   Role
//   chars    in         ch[7:0], is_end                               host name characters
//   qname    out        out_byte[7:0], last_of_run, name_done,        QNAME wire bytes
//                       err_code[1:0]
//
// A character word that is not a dot is written into the label RAM unless the
// label is full or input is being dropped. A dot closing a label sends the
// length byte, then the stored bytes as the RAM read port replays the label,
// then returns to idle; an end word adds the terminating zero. The RAM read
// port, one byte per cycle while the qname channel does not stall, sets the rate.
// Reset clears the controller, the label count and the name flags; the RAM is
// not cleared and needs no clearing pass. A stalled qname channel holds the
// output register and pauses the replay; chars is taken only in idle.
module dns_qname_label_encoder import dqe_pkg::*; #(
	parameter int MAX_LABEL = 62
) (
	input  logic         clk,
	input  logic         arst_n,
	dqe_in_if.sink       chars,
	dqe_out_if.source    qname
);

	// RAM address width; a one-entry label still gets a one-bit address.
	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	ctrl_state_t state_q, state_d;

	// Characters held for the current label, and the replay read index.
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;

	// Name flags: no character seen yet, and discarding input after an error.
	logic at_start_q, at_start_d;
	logic drop_q, drop_d;

	// The flush in progress came from an end word, so the zero byte follows.
	logic end_pend_q, end_pend_d;
	logic [1:0] err_q, err_d;

	// Output register.
	logic      out_valid_q;
	out_word_t out_word_q;
	out_word_t word_d;
	logic      load;
	logic      slot_free;

	// RAM ports.
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign chars.ready = (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || qname.ready;

	dqe_label_ram #(
		.DEPTH (MAX_LABEL),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (chars.ch),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			at_start_q <= 1'b1;
			drop_q     <= 1'b0;
			end_pend_q <= 1'b0;
			err_q      <= ERR_OK;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			at_start_q <= at_start_d;
			drop_q     <= drop_d;
			end_pend_q <= end_pend_d;
			err_q      <= err_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		at_start_d = at_start_q;
		drop_d     = drop_q;
		end_pend_d = end_pend_q;
		err_d      = err_q;
		load       = 1'b0;
		word_d     = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = '0;

		case (state_q)
			ST_IDLE: begin
				if (chars.valid) begin
					if (chars.is_end) begin
						// An end word closes the name whether or not we were dropping.
						at_start_d = 1'b1;
						drop_d     = 1'b0;
						if (!drop_q) begin
							if (count_q != '0) begin
								end_pend_d = 1'b1;
								state_d    = ST_LEN;
							end else begin
								state_d = ST_END;
							end
						end else begin
							count_d = '0;
						end
					end else if (drop_q) begin
						state_d = ST_IDLE;
					end else if (chars.ch == DOT_CHAR) begin
						if (at_start_q || count_q == '0) begin
							err_d   = at_start_q ? ERR_LEADING_DOT : ERR_EMPTY_LABEL;
							drop_d  = 1'b1;
							count_d = '0;
							state_d = ST_ERR;
						end else begin
							end_pend_d = 1'b0;
							state_d    = ST_LEN;
						end
					end else begin
						at_start_d = 1'b0;
						if (count_q >= CNT_W'(MAX_LABEL)) begin
							err_d   = ERR_TOO_LONG;
							drop_d  = 1'b1;
							count_d = '0;
							state_d = ST_ERR;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + 1'b1;
						end
					end
				end
			end
			ST_LEN: begin
				// Length byte goes out while the first character is fetched.
				if (slot_free) begin
					load      = 1'b1;
					word_d    = '{out_byte: 8'(count_q), last_of_run: 1'b0,
						name_done: 1'b0, err_code: ERR_OK};
					ram_re    = 1'b1;
					ram_raddr = '0;
					idx_d     = CNT_W'(1);
					state_d   = ST_DATA;
				end
			end
			ST_DATA: begin
				if (slot_free) begin
					load   = 1'b1;
					word_d = '{out_byte: ram_rdata, last_of_run: 1'b0,
						name_done: 1'b0, err_code: ERR_OK};
					if (idx_q < count_q) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q[AW-1:0];
						idx_d     = idx_q + 1'b1;
					end else begin
						word_d.last_of_run = !end_pend_q;
						count_d            = '0;
						state_d            = end_pend_q ? ST_END : ST_IDLE;
					end
				end
			end
			ST_END: begin
				if (slot_free) begin
					load       = 1'b1;
					word_d     = '{out_byte: END_BYTE, last_of_run: 1'b1,
						name_done: 1'b1, err_code: ERR_OK};
					end_pend_d = 1'b0;
					count_d    = '0;
					state_d    = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					load    = 1'b1;
					word_d  = '{out_byte: END_BYTE, last_of_run: 1'b1,
						name_done: 1'b1, err_code: err_q};
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The output register takes a new word only when it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (qname.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= word_d;
		end
	end

	assign qname.valid       = out_valid_q;
	assign qname.out_byte    = out_word_q.out_byte;
	assign qname.last_of_run = out_word_q.last_of_run;
	assign qname.name_done   = out_word_q.name_done;
	assign qname.err_code    = out_word_q.err_code;

endmodule
